@@ rtl/dlcg_pkg.sv @@
// ----------------------------------------------------------------------------
// dlcg_pkg
// Shared constants, types, microcode encoding and the quarter-wave sine table
// for the decaying linear chirp generator.
// ----------------------------------------------------------------------------
package dlcg_pkg;

  // Sine table and phase geometry
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int PHASE_BITS         = 32;
  localparam int SINE_QUARTER       = SINE_TABLE_ENTRIES / 4;
  localparam int SINE_FULL          = SINE_QUARTER * 4;
  localparam int IDX_W              = $clog2(SINE_FULL);
  localparam int FULL_W             = $clog2(SINE_FULL + 1);
  localparam int IDX_PROD_W         = PHASE_BITS + FULL_W;
  localparam int ADDR_W             = $clog2(SINE_QUARTER + 1);
  localparam int QIDX_W             = $clog2(SINE_QUARTER);

  // Field widths
  localparam int INC_W    = 32;
  localparam int SINE_W   = 15;
  localparam int ENV_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int START_W  = 31;
  localparam int ISTEP_W  = 25;
  localparam int LEN_W    = 16;
  localparam int DECAY_W  = 16;
  localparam int AMP_W    = 15;
  localparam int P1_W     = SINE_W + ENV_W;
  localparam int P2_W     = P1_W + AMP_W;
  localparam int MAG_W    = P2_W - 31;

  localparam logic [ENV_W-1:0]   ENV_FULL    = 16'hFFFF;
  localparam logic [AMP_W-1:0]   AMP_RESET   = 15'd28000;
  localparam logic [LEN_W-1:0]   LEN_RESET   = 16'd1;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'hFFFF;

  // Register file port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int RIDX_W  = PADDR_W - 2;

  localparam logic [RIDX_W-1:0] REG_START_INC = 3'd0;
  localparam logic [RIDX_W-1:0] REG_INC_STEP  = 3'd1;
  localparam logic [RIDX_W-1:0] REG_LENGTH    = 3'd2;
  localparam logic [RIDX_W-1:0] REG_DECAY     = 3'd3;
  localparam logic [RIDX_W-1:0] REG_AMPLITUDE = 3'd4;

  typedef struct packed {
    logic [START_W-1:0]        start_increment;
    logic signed [ISTEP_W-1:0] increment_step;
    logic [LEN_W-1:0]          length_samples;
    logic [DECAY_W-1:0]        decay_factor;
    logic [AMP_W-1:0]          amplitude;
  } cfg_t;

  // Microcode
  typedef logic [3:0] step_t;

  localparam step_t STEP_WAIT  = 4'd0;
  localparam step_t STEP_CHECK = 4'd1;
  localparam step_t STEP_PHASE = 4'd2;
  localparam step_t STEP_INDEX = 4'd3;
  localparam step_t STEP_QUAD  = 4'd4;
  localparam step_t STEP_SINE  = 4'd5;
  localparam step_t STEP_ENV   = 4'd6;
  localparam step_t STEP_AMP   = 4'd7;
  localparam step_t STEP_UPD   = 4'd8;
  localparam step_t STEP_EMIT  = 4'd9;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_IF_IDLE,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    logic  accept;
    logic  ld_phase;
    logic  ld_index;
    logic  ld_addr;
    logic  ld_sine;
    logic  ld_env;
    logic  ld_amp;
    logic  ld_upd;
    logic  emit;
    jmp_t  jmp;
    step_t target;
  } ucode_t;

  // Strobes from sequencer to datapath
  typedef struct packed {
    logic accept;
    logic ld_phase;
    logic ld_index;
    logic ld_addr;
    logic ld_sine;
    logic ld_env;
    logic ld_amp;
    logic ld_upd;
    logic emit;
  } dp_ctrl_t;

  typedef struct packed {
    logic active;
    logic out_free;
  } dp_status_t;

  // Sine polynomial coefficients, Q30
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598668;
  localparam logic [63:0] SIN_C5 = 64'd85569307;
  localparam logic [63:0] SIN_C7 = 64'd5026995;
  localparam logic [63:0] SIN_C9 = 64'd172272;

  typedef logic [SINE_W-1:0] qtab_t [SINE_QUARTER];

  // One quarter-wave entry, rounded unsigned Q0.15, evaluated at elaboration only
  function automatic logic [SINE_W-1:0] quarter_sine(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(k) << 30) / 64'(SINE_QUARTER);
    x2 = (x * x) >> 30;
    s  = SIN_C9;
    s  = SIN_C7 - ((x2 * s) >> 30);
    s  = SIN_C5 - ((x2 * s) >> 30);
    s  = SIN_C3 - ((x2 * s) >> 30);
    s  = SIN_C1 - ((x2 * s) >> 30);
    v  = (x * s) >> 30;
    v  = (v + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k < SINE_QUARTER; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

  localparam qtab_t              QTAB = build_qtab();
  localparam logic [SINE_W-1:0]  QTOP = quarter_sine(SINE_QUARTER);

endpackage

@@ rtl/dlcg_regs.sv @@
// ----------------------------------------------------------------------------
// dlcg_regs
// APB-style configuration register file for the chirp generator.
// ----------------------------------------------------------------------------
module dlcg_regs import dlcg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic              wr_en;
  logic [RIDX_W-1:0] ridx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign ridx   = paddr[PADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_increment <= '0;
      cfg.increment_step  <= '0;
      cfg.length_samples  <= LEN_RESET;
      cfg.decay_factor    <= DECAY_RESET;
      cfg.amplitude       <= AMP_RESET;
    end else if (wr_en) begin
      unique case (ridx)
        REG_START_INC: cfg.start_increment <= pwdata[START_W-1:0];
        REG_INC_STEP:  cfg.increment_step  <= pwdata[ISTEP_W-1:0];
        REG_LENGTH:    cfg.length_samples  <= pwdata[LEN_W-1:0];
        REG_DECAY:     cfg.decay_factor    <= pwdata[DECAY_W-1:0];
        REG_AMPLITUDE: cfg.amplitude       <= pwdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux; step reads back sign-extended
  always_comb begin
    unique case (ridx)
      REG_START_INC: prdata = PDATA_W'(cfg.start_increment);
      REG_INC_STEP:  prdata = PDATA_W'(cfg.increment_step);
      REG_LENGTH:    prdata = PDATA_W'(cfg.length_samples);
      REG_DECAY:     prdata = PDATA_W'(cfg.decay_factor);
      REG_AMPLITUDE: prdata = PDATA_W'(cfg.amplitude);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ rtl/dlcg_seq.sv @@
// ----------------------------------------------------------------------------
// dlcg_seq
// Microcode sequencer: step counter, control ROM and jump logic.
// ----------------------------------------------------------------------------
module dlcg_seq import dlcg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_ctrl_t   ctl
);

  step_t  step;
  step_t  step_next;
  ucode_t word;

  // Control ROM, one word per step
  function automatic ucode_t rom(input step_t s);
    ucode_t w;
    w        = '0;
    w.jmp    = JMP_NEXT;
    w.target = STEP_WAIT;
    unique case (s)
      STEP_WAIT: begin
        w.accept = 1'b1;
        w.jmp    = JMP_WAIT_IN;
      end
      STEP_CHECK: w.jmp      = JMP_IF_IDLE;
      STEP_PHASE: w.ld_phase = 1'b1;
      STEP_INDEX: w.ld_index = 1'b1;
      STEP_QUAD:  w.ld_addr  = 1'b1;
      STEP_SINE:  w.ld_sine  = 1'b1;
      STEP_ENV:   w.ld_env   = 1'b1;
      STEP_AMP:   w.ld_amp   = 1'b1;
      STEP_UPD:   w.ld_upd   = 1'b1;
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.jmp  = JMP_WAIT_OUT;
      end
      default: w.jmp = JMP_IF_IDLE;  // unused codes fall back to wait
    endcase
    return w;
  endfunction

  assign word = rom(step);

  // Gated strobes
  always_comb begin
    ctl          = '0;
    ctl.accept   = word.accept & in_valid;
    ctl.ld_phase = word.ld_phase;
    ctl.ld_index = word.ld_index;
    ctl.ld_addr  = word.ld_addr;
    ctl.ld_sine  = word.ld_sine;
    ctl.ld_env   = word.ld_env;
    ctl.ld_amp   = word.ld_amp;
    ctl.ld_upd   = word.ld_upd;
    ctl.emit     = word.emit & status.out_free;
  end

  assign in_stall = ~word.accept;

  // Next step
  always_comb begin
    step_next = step + 4'd1;
    unique case (word.jmp)
      JMP_NEXT:    step_next = step + 4'd1;
      JMP_WAIT_IN: step_next = in_valid ? step + 4'd1 : step;
      JMP_IF_IDLE: step_next = status.active ? step + 4'd1 : word.target;
      JMP_WAIT_OUT: step_next = status.out_free ? word.target : step;
      default:     step_next = STEP_WAIT;
    endcase
    if (step > STEP_EMIT) begin
      step_next = STEP_WAIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

`ifndef SYNTHESIS
  // A transfer always moves on to the activity check
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |=> step == STEP_CHECK)
    else $error("sequencer did not leave wait step after transfer");

  // After a result is loaded the program returns to wait
  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> step == STEP_WAIT)
    else $error("sequencer did not return after emit");

  // A blocked output holds the emit step
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_EMIT && !status.out_free) |=> step == STEP_EMIT)
    else $error("emit step left while output busy");
`endif

endmodule

@@ rtl/dlcg_datapath.sv @@
// ----------------------------------------------------------------------------
// dlcg_datapath
// Phase, sine lookup, envelope and amplitude datapath with output register.
// ----------------------------------------------------------------------------
module dlcg_datapath import dlcg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  dp_ctrl_t                   ctl,
  input  logic                       restart,
  output dp_status_t                 status,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       last
);

  // Sweep state
  logic [PHASE_BITS-1:0] phase;
  logic [INC_W-1:0]      inc;
  logic [ENV_W-1:0]      env;
  logic [LEN_W-1:0]      left;
  logic                  active;

  // Per-sample working registers
  logic [IDX_W-1:0]  index;
  logic [ADDR_W-1:0] addr;
  logic              neg;
  logic [SINE_W-1:0] sine_mag;
  logic [P1_W-1:0]   p1;
  logic [MAG_W-1:0]  mag;

  logic [IDX_PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]      k_full;
  logic [1:0]            quad;
  logic [ADDR_W-1:0]     k_q;
  logic [ADDR_W-1:0]     addr_next;
  logic [SINE_W-1:0]     sine_next;
  logic [P2_W-1:0]       p2;
  logic [31:0]           env_prod;
  logic [LEN_W-1:0]      left_dec;
  logic [INC_W-1:0]      step_ext;
  logic                  out_free;

  // Full-cycle table index = (phase * FULL) >> PHASE_BITS
  assign idx_prod = IDX_PROD_W'(phase) * IDX_PROD_W'(SINE_FULL);

  // Quadrant split by compare, mirror odd quadrants
  always_comb begin
    if (index < IDX_W'(SINE_QUARTER)) begin
      quad   = 2'd0;
      k_full = index;
    end else if (index < IDX_W'(2 * SINE_QUARTER)) begin
      quad   = 2'd1;
      k_full = index - IDX_W'(SINE_QUARTER);
    end else if (index < IDX_W'(3 * SINE_QUARTER)) begin
      quad   = 2'd2;
      k_full = index - IDX_W'(2 * SINE_QUARTER);
    end else begin
      quad   = 2'd3;
      k_full = index - IDX_W'(3 * SINE_QUARTER);
    end
    k_q       = ADDR_W'(k_full);
    addr_next = quad[0] ? ADDR_W'(SINE_QUARTER) - k_q : k_q;
  end

  // Quarter table; the peak entry sits past the table proper
  assign sine_next = (addr == ADDR_W'(SINE_QUARTER)) ? QTOP : QTAB[addr[QIDX_W-1:0]];

  assign p2       = P2_W'(p1) * P2_W'(cfg.amplitude);
  assign env_prod = 32'(env) * 32'(cfg.decay_factor);
  assign left_dec = left - LEN_W'(1);
  assign step_ext = INC_W'(cfg.increment_step);
  assign out_free = ~out_valid | ~out_stall;

  assign status.active   = active;
  assign status.out_free = out_free;

  // Sweep state: restart load and per-sample update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      inc    <= '0;
      env    <= ENV_FULL;
      left   <= '0;
      active <= 1'b0;
    end else if (ctl.accept && restart) begin
      phase  <= '0;
      inc    <= INC_W'(cfg.start_increment);
      env    <= ENV_FULL;
      left   <= cfg.length_samples;
      active <= (cfg.length_samples != '0);
    end else begin
      if (ctl.ld_phase) begin
        phase <= phase + inc[INC_W-1 -: PHASE_BITS];
      end
      if (ctl.ld_upd) begin
        inc    <= inc + step_ext;
        env    <= env_prod[31:16];
        left   <= left_dec;
        active <= (left_dec != '0);
      end
    end
  end

  // Working registers, one multiply per step
  always_ff @(posedge clk) begin
    if (ctl.ld_index) begin
      index <= idx_prod[PHASE_BITS +: IDX_W];
    end
    if (ctl.ld_addr) begin
      addr <= addr_next;
      neg  <= quad[1];
    end
    if (ctl.ld_sine) begin
      sine_mag <= sine_next;
    end
    if (ctl.ld_env) begin
      p1 <= P1_W'(sine_mag) * P1_W'(env);
    end
    if (ctl.ld_amp) begin
      mag <= p2[P2_W-1:31];  // magnitude stays below 2^15, no clipping needed
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      sample <= neg ? SAMPLE_W'(0) - SAMPLE_W'(mag) : SAMPLE_W'(mag);
      last   <= ~active;
    end
  end

`ifndef SYNTHESIS
  // A loaded result is presented on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> out_valid)
    else $error("result not presented after emit");

  // A restart with a nonzero length starts a sweep
  a_restart_active: assert property (@(posedge clk) disable iff (rst)
    (ctl.accept && restart && cfg.length_samples != '0) |=> active)
    else $error("sweep not started on restart");

  // Emit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!out_valid || !out_stall))
    else $error("output overwritten while stalled");
`endif

endmodule

@@ rtl/decaying_linear_chirp_generator.sv @@
// ----------------------------------------------------------------------------
// decaying_linear_chirp_generator
// Linear chirp with exponential envelope, at most one sample per tick transfer.
// ----------------------------------------------------------------------------
// Each tick transfer on the input channel yields at most one sample. A tick
// with restart set begins a sweep of length_samples samples; ticks while no
// sweep runs give no result, only passing the activity check. A sample is
// loaded into the output register after the phase, index, quadrant, sine,
// envelope, amplitude and update steps, once emit finds the output free; the
// ten-step microcode program runs the shared datapath one multiply per step.
// The next tick can be taken in the cycle after the load, never while a
// sample is in work, so a stalled output only holds the block when a second
// result is ready. The last flag marks the final sample of a sweep. The user
// must write registers through the APB port only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module decaying_linear_chirp_generator import dlcg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  // Tick input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       restart,
  // Sample output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       last
);

  cfg_t       cfg;
  dp_ctrl_t   ctl;
  dp_status_t status;

  dlcg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dlcg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  dlcg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctl       (ctl),
    .restart   (restart),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .last      (last)
  );

endmodule
